// ===== sv/sah_split_plane_sweep_core_assert.svh =====
// Assertion macros for the split-plane sweep core.
`ifndef SAH_SPLIT_PLANE_SWEEP_CORE_ASSERT_SVH
`define SAH_SPLIT_PLANE_SWEEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SAH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define SAH_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m: forbidden");
`else
`define SAH_ASSERT(lbl, prop)
`define SAH_NEVER(lbl, cond)
`endif
`endif

// ===== sv/sah_pkg.sv =====
`timescale 1ns / 1ps
package sah_pkg;

  localparam int CNT_W  = 17;
  localparam int POS_W  = 32;
  localparam int AX_W   = 2;
  localparam int KIND_W = 2;
  localparam int DIV_W  = 48;
  localparam int Q_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [CNT_W-1:0] MAX_TRI = 17'd65536;

  localparam logic [AX_W-1:0] AX_X    = 2'd0;
  localparam logic [AX_W-1:0] AX_Y    = 2'd1;
  localparam logic [AX_W-1:0] AX_Z    = 2'd2;
  localparam logic [AX_W-1:0] AX_NULL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_END    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLANAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NULL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_TRI = 3'd6;

  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [16:0] ISECT_Q16      = 17'd91750;
  localparam logic [15:0] BIAS_BASE_Q16  = 16'd52429;
  localparam logic [13:0] BIAS_SLOPE_Q16 = 14'd13107;
  localparam logic [31:0] COST_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_MAX        = 32'h7FFF_FFFF;

  typedef struct packed {
    logic              close;
    logic              emit;
    logic [AX_W-1:0]   ax;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  nl;
    logic [CNT_W-1:0]  np;
    logic [CNT_W-1:0]  nr;
  } q_entry_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_EXT, BK_LEN, BK_M1, BK_M2, BK_M3, BK_M4, BK_AREA, BK_NORM,
    BK_DIV_GO, BK_DIV_WAIT, BK_BIAS, BK_W1, BK_W2, BK_W3, BK_C, BK_CB,
    BK_PICK, BK_KEEP, BK_THR, BK_EMIT
  } back_state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, MAX_TRI}) ? MAX_TRI : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] load_count(input logic [CNT_W-1:0] vt);
    return (vt > MAX_TRI) ? MAX_TRI : vt;
  endfunction

endpackage

// ===== sv/sah_div.sv =====
`timescale 1ns / 1ps
module sah_div import sah_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   q
);

  logic             busy_r, done_r;
  logic [4:0]       cnt_r;
  logic [DIV_W-1:0] rem_r, den_r;
  logic [Q_W-1:0]   q_r;

  logic [DIV_W:0]   trial;
  logic             fits;
  logic [DIV_W-1:0] rem_nxt;

  always_comb begin
    trial   = (cnt_r == 5'd0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== sv/sah_fifo.sv =====
`timescale 1ns / 1ps
module sah_fifo import sah_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_data,
  input  logic     pop,
  output q_entry_t rd_data,
  output logic     full,
  output logic     empty
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_data;
  end

  assign rd_data = mem_r[rptr_r];
  assign full    = cnt_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;

endmodule

// ===== sv/sah_front.sv =====
`timescale 1ns / 1ps
module sah_front import sah_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AX_W-1:0]   ev_ax,
  input  logic [POS_W-1:0]  ev_pos,
  input  logic [KIND_W-1:0] ev_kind,
  input  logic              ev_last,
  input  logic [CNT_W-1:0]  lc,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_data
);

  logic [AX_W-1:0]  cur_r, cur_nxt;
  logic [POS_W-1:0] gpos_r, gpos_nxt;
  logic             open_r, open_nxt, flush_r, flush_nxt;
  logic [CNT_W-1:0] ge_r, gp_r, gs_r, cl_r, cr_r;
  logic [CNT_W-1:0] ge_nxt, gp_nxt, gs_nxt, cl_nxt, cr_nxt;

  logic [CNT_W-1:0] sub, nr_c, cl_after;
  logic             fire, ev_ok, new_axis, new_group, close_a;

  always_comb begin
    sub      = sat_add(gp_r, ge_r);
    nr_c     = (cr_r > sub) ? cr_r - sub : '0;
    cl_after = sat_add(cl_r, sat_add(gs_r, gp_r));
    in_ready = !flush_r && !q_full;
    fire     = in_valid && in_ready;
    ev_ok    = (ev_ax != AX_NULL) && (ev_kind != KIND_NULL);
    new_axis  = !open_r || (ev_ax != cur_r);
    new_group = new_axis || (ev_pos != gpos_r);
    close_a   = fire && ev_ok && open_r && new_group;
    q_push    = close_a || (flush_r && !q_full);
    q_data    = '{close: flush_r ? open_r : 1'b1, emit: flush_r, ax: cur_r,
                  pos: gpos_r, nl: cl_r, np: gp_r, nr: nr_c};
  end

  always_comb begin
    cur_nxt   = cur_r;
    gpos_nxt  = gpos_r;
    open_nxt  = open_r;
    ge_nxt    = ge_r;
    gp_nxt    = gp_r;
    gs_nxt    = gs_r;
    cl_nxt    = cl_r;
    cr_nxt    = cr_r;
    flush_nxt = flush_r;
    if (flush_r) begin
      if (!q_full) begin
        cur_nxt   = AX_X;
        gpos_nxt  = '0;
        open_nxt  = 1'b0;
        ge_nxt    = '0;
        gp_nxt    = '0;
        gs_nxt    = '0;
        cl_nxt    = '0;
        cr_nxt    = lc;
        flush_nxt = 1'b0;
      end
    end else if (fire) begin
      if (ev_ok) begin
        if (close_a) begin
          cl_nxt = cl_after;
          cr_nxt = nr_c;
        end
        if (new_axis) begin
          cl_nxt  = '0;
          cr_nxt  = lc;
          cur_nxt = ev_ax;
        end
        if (new_group) begin
          gpos_nxt = ev_pos;
          ge_nxt   = '0;
          gp_nxt   = '0;
          gs_nxt   = '0;
          open_nxt = 1'b1;
        end
        case (ev_kind)
          KIND_END:    ge_nxt = sat_add(ge_nxt, CNT_W'(1));
          KIND_PLANAR: gp_nxt = sat_add(gp_nxt, CNT_W'(1));
          default:     gs_nxt = sat_add(gs_nxt, CNT_W'(1));
        endcase
      end
      if (ev_last) flush_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= AX_X;
      gpos_r  <= '0;
      open_r  <= 1'b0;
      ge_r    <= '0;
      gp_r    <= '0;
      gs_r    <= '0;
      cl_r    <= '0;
      cr_r    <= '0;
      flush_r <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      gpos_r  <= gpos_nxt;
      open_r  <= open_nxt;
      ge_r    <= ge_nxt;
      gp_r    <= gp_nxt;
      gs_r    <= gs_nxt;
      cl_r    <= cl_nxt;
      cr_r    <= cr_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

// ===== sv/sah_back.sv =====
`timescale 1ns / 1ps
module sah_back import sah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_entry_t              q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [2:0][POS_W-1:0] box_lo,
  input  logic [2:0][POS_W-1:0] box_hi,
  input  logic [CNT_W-1:0]      lc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AX_W-1:0]       best_axis,
  output logic [POS_W-1:0]      best_position,
  output logic [31:0]           best_cost,
  output logic                  planar_side,
  output logic                  make_leaf
);

  function automatic logic [POS_W-1:0] pick3(input logic [2:0][POS_W-1:0] v,
                                             input logic [AX_W-1:0] a);
    case (a)
      AX_Y:    return v[1];
      AX_Z:    return v[2];
      default: return v[0];
    endcase
  endfunction

  function automatic logic [AX_W-1:0] nxt_ax(input logic [AX_W-1:0] a);
    case (a)
      AX_X:    return AX_Y;
      AX_Y:    return AX_Z;
      default: return AX_X;
    endcase
  endfunction

  back_state_t st_r, st_nxt;

  q_entry_t              ent_r;
  logic [2:0][POS_W-1:0] ext_r;
  logic                  scl_r;
  logic signed [32:0]    dpos_r;
  logic [31:0]           ea_r, lenl_r, lenr_r;
  logic [30:0]           sa_r, sb_r, sc_r, sl_r, sr_r;
  logic [31:0]           bc_r;
  logic [62:0]           pa_r, pbc_r, pl_r, pr_r;
  logic [63:0]           area_r, areal_r, arear_r;
  logic [46:0]           an_r, anl_r, anr_r;
  logic [1:0]            didx_r;
  logic [Q_W-1:0]        pq_r [4];
  logic [16:0]           bl_r, br_r;
  logic                  j_r;
  logic [17:0]           na_r, nb_r;
  logic [34:0]           t1_r, t2_r;
  logic [52:0]           t3_r;
  logic [37:0]           c_r;
  logic [31:0]           cost_r [2];
  logic [31:0]           cand_r;
  logic                  cside_r;
  logic [AX_W-1:0]       kax_r;
  logic [POS_W-1:0]      kpos_r;
  logic [31:0]           kcost_r;
  logic                  kside_r;
  logic [33:0]           thr_r;
  logic                  ov_r;
  logic [AX_W-1:0]       oax_r;
  logic [POS_W-1:0]      opos_r;
  logic [31:0]           ocost_r;
  logic                  oside_r, oleaf_r;

  logic                  div_start, div_done, out_load, zero_area;
  logic [Q_W-1:0]        div_q;
  logic [DIV_W-1:0]      div_num, div_den;

  logic [2:0][POS_W-1:0] ext_c;
  logic signed [32:0]    diff_c [3];
  logic                  scl_c;
  logic [POS_W-1:0]      lo_a;
  logic signed [32:0]    dpos_c;
  logic [31:0]           ea_c, eb_c, ec_c, lenl_c;
  logic [30:0]           sa_c, sb_c, sc_c, sl_c;
  logic [4:0]            sh_c;
  logic [30:0]           mbl_c, mbr_c;
  logic [17:0]           na_c, nb_c;
  logic [35:0]           w_c;
  logic [16:0]           bsel_c;
  logic [54:0]           cprod_c;
  logic [38:0]           cb_c;
  logic [31:0]           csat_c;

  always_comb begin
    scl_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = $signed({box_hi[i][31], box_hi[i]}) - $signed({box_lo[i][31], box_lo[i]});
      ext_c[i]  = diff_c[i][32] ? '0 : diff_c[i][31:0];
      scl_c     = scl_c | ext_c[i][31];
    end
    lo_a   = pick3(box_lo, ent_r.ax);
    dpos_c = $signed({ent_r.pos[31], ent_r.pos}) - $signed({lo_a[31], lo_a});

    ea_c = pick3(ext_r, ent_r.ax);
    eb_c = pick3(ext_r, nxt_ax(ent_r.ax));
    ec_c = pick3(ext_r, nxt_ax(nxt_ax(ent_r.ax)));
    if (dpos_r[32])             lenl_c = '0;
    else if (dpos_r[31:0] > ea_c) lenl_c = ea_c;
    else                        lenl_c = dpos_r[31:0];
    sa_c = scl_r ? ea_c[31:1]   : ea_c[30:0];
    sb_c = scl_r ? eb_c[31:1]   : eb_c[30:0];
    sc_c = scl_r ? ec_c[31:1]   : ec_c[30:0];
    sl_c = scl_r ? lenl_c[31:1] : lenl_c[30:0];

    zero_area = (area_r == '0) || (ea_r == '0);
    sh_c = '0;
    for (int k = 47; k < 64; k++) begin
      if (area_r[k]) sh_c = 5'(k - 46);
    end

    case (didx_r)
      2'd0:    begin div_num = {1'b0, anl_r};       div_den = {1'b0, an_r};        end
      2'd1:    begin div_num = {1'b0, anr_r};       div_den = {1'b0, an_r};        end
      2'd2:    begin div_num = {16'b0, lenl_r};     div_den = {16'b0, ea_r};       end
      default: begin div_num = {16'b0, lenr_r};     div_den = {16'b0, ea_r};       end
    endcase

    mbl_c = BIAS_SLOPE_Q16 * pq_r[2];
    mbr_c = BIAS_SLOPE_Q16 * pq_r[3];

    na_c = j_r ? {1'b0, ent_r.nl} : {1'b0, ent_r.nl} + {1'b0, ent_r.np};
    nb_c = j_r ? {1'b0, ent_r.np} + {1'b0, ent_r.nr} : {1'b0, ent_r.nr};
    w_c  = {1'b0, t1_r} + {1'b0, t2_r};

    bsel_c  = (na_r == '0) ? br_r : bl_r;
    cprod_c = c_r * bsel_c;
    if (na_r == '0 || nb_r == '0) cb_c = cprod_c[54:16];
    else                          cb_c = {1'b0, c_r};
    csat_c = (cb_c > {7'b0, COST_MAX}) ? COST_MAX : cb_c[31:0];
  end

  sah_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.close)     st_nxt = BK_EXT;
          else if (q_data.emit) st_nxt = BK_THR;
        end
      end
      BK_EXT:      st_nxt = BK_LEN;
      BK_LEN:      st_nxt = BK_M1;
      BK_M1:       st_nxt = BK_M2;
      BK_M2:       st_nxt = BK_M3;
      BK_M3:       st_nxt = BK_M4;
      BK_M4:       st_nxt = BK_AREA;
      BK_AREA:     st_nxt = BK_NORM;
      BK_NORM:     st_nxt = zero_area ? BK_PICK : BK_DIV_GO;
      BK_DIV_GO:   st_nxt = BK_DIV_WAIT;
      BK_DIV_WAIT: begin
        if (div_done) st_nxt = (didx_r == 2'd3) ? BK_BIAS : BK_DIV_GO;
      end
      BK_BIAS:     st_nxt = BK_W1;
      BK_W1:       st_nxt = BK_W2;
      BK_W2:       st_nxt = BK_W3;
      BK_W3:       st_nxt = BK_C;
      BK_C:        st_nxt = BK_CB;
      BK_CB:       st_nxt = j_r ? BK_PICK : BK_W1;
      BK_PICK:     st_nxt = BK_KEEP;
      BK_KEEP:     st_nxt = ent_r.emit ? BK_THR : BK_IDLE;
      BK_THR:      st_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!ov_r || out_ready) st_nxt = BK_IDLE;
      end
      default:     st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (st_r == BK_IDLE) && !q_empty;
    div_start = (st_r == BK_DIV_GO);
    out_load  = (st_r == BK_EMIT) && (!ov_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      ov_r    <= 1'b0;
      kax_r   <= AX_X;
      kpos_r  <= POS_MAX;
      kcost_r <= COST_MAX;
      kside_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load)              ov_r <= 1'b1;
      else if (out_ready)        ov_r <= 1'b0;
      if (st_r == BK_KEEP && cand_r < kcost_r) begin
        kcost_r <= cand_r;
        kside_r <= cside_r;
        kax_r   <= ent_r.ax;
        kpos_r  <= ent_r.pos;
      end else if (out_load) begin
        kax_r   <= AX_X;
        kpos_r  <= POS_MAX;
        kcost_r <= COST_MAX;
        kside_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ent_r <= q_data;
    case (st_r)
      BK_EXT: begin
        ext_r  <= ext_c;
        scl_r  <= scl_c;
        dpos_r <= dpos_c;
      end
      BK_LEN: begin
        ea_r   <= ea_c;
        lenl_r <= lenl_c;
        lenr_r <= ea_c - lenl_c;
        sa_r   <= sa_c;
        sb_r   <= sb_c;
        sc_r   <= sc_c;
        sl_r   <= sl_c;
        sr_r   <= sa_c - sl_c;
        bc_r   <= {1'b0, sb_c} + {1'b0, sc_c};
      end
      BK_M1: pa_r  <= sa_r * bc_r;
      BK_M2: pbc_r <= sb_r * sc_r;
      BK_M3: pl_r  <= sl_r * bc_r;
      BK_M4: pr_r  <= sr_r * bc_r;
      BK_AREA: begin
        area_r  <= {1'b0, pa_r} + {1'b0, pbc_r};
        areal_r <= {1'b0, pl_r} + {1'b0, pbc_r};
        arear_r <= {1'b0, pr_r} + {1'b0, pbc_r};
      end
      BK_NORM: begin
        an_r   <= 47'(area_r >> sh_c);
        anl_r  <= 47'(areal_r >> sh_c);
        anr_r  <= 47'(arear_r >> sh_c);
        didx_r <= 2'd0;
        cost_r[0] <= COST_MAX;
        cost_r[1] <= COST_MAX;
      end
      BK_DIV_WAIT: begin
        if (div_done) begin
          pq_r[didx_r] <= div_q;
          didx_r       <= didx_r + 2'd1;
        end
      end
      BK_BIAS: begin
        bl_r <= 17'(BIAS_BASE_Q16) + 17'(mbl_c[30:16]);
        br_r <= 17'(BIAS_BASE_Q16) + 17'(mbr_c[30:16]);
        j_r  <= 1'b0;
      end
      BK_W1: begin
        na_r <= na_c;
        nb_r <= nb_c;
        t1_r <= pq_r[0] * na_c;
      end
      BK_W2: t2_r <= pq_r[1] * nb_r;
      BK_W3: t3_r <= w_c * ISECT_Q16;
      BK_C:  c_r  <= 38'(ONE_Q16) + 38'(t3_r[52:16]);
      BK_CB: begin
        cost_r[j_r] <= csat_c;
        j_r         <= 1'b1;
      end
      BK_PICK: begin
        if (cost_r[0] <= cost_r[1]) begin
          cand_r  <= cost_r[0];
          cside_r <= 1'b0;
        end else begin
          cand_r  <= cost_r[1];
          cside_r <= 1'b1;
        end
      end
      BK_THR: thr_r <= ISECT_Q16 * lc;
      default: ;
    endcase
    if (out_load) begin
      oax_r   <= kax_r;
      opos_r  <= kpos_r;
      ocost_r <= kcost_r;
      oside_r <= kside_r;
      oleaf_r <= (kcost_r == COST_MAX) || ({2'b0, kcost_r} >= thr_r);
    end
  end

  assign out_valid     = ov_r;
  assign best_axis     = oax_r;
  assign best_position = opos_r;
  assign best_cost     = ocost_r;
  assign planar_side   = oside_r;
  assign make_leaf     = oleaf_r;

endmodule

// ===== sv/sah_split_plane_sweep_core.sv =====
`timescale 1ns / 1ps
`include "sah_split_plane_sweep_core_assert.svh"
// SAH split-plane sweep for one kd-tree node. Sorted split events enter one per
// cycle while the front is not flushing and the queue is not full; the front counts
// them per group and hands every closed group, plus the end-of-sweep request, to a
// four-entry queue. The back evaluates each closed group mostly in the shared
// bit-serial divider (four 17-step quotients), so once the queue fills the sweep
// runs at the pace of the back. A set tlast stalls the front while it pushes the
// end-of-sweep request; after the back has drained, the best plane passes through
// the threshold and emit states to the output register. Write the box and triangle count only while idle.
module sah_split_plane_sweep_core import sah_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,  // axis[1:0], position[33:2], zero pad
  input  logic [KIND_W-1:0]    in_tuser,  // kind[1:0]
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // best_axis[1:0], best_position[33:2], best_cost[65:34], planar_side[66],
  // make_leaf[67], zero pad
  output logic [71:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [2:0][POS_W-1:0] box_lo_r, box_hi_r;
  logic [CNT_W-1:0]      vt_r, lc;

  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wr, q_rd;

  logic [AX_W-1:0]  best_axis;
  logic [POS_W-1:0] best_position;
  logic [31:0]      best_cost;
  logic             planar_side, make_leaf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r <= '0;
      box_hi_r <= '0;
      vt_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_X:     box_lo_r[0] <= cfg_wdata;
        CFG_MIN_Y:     box_lo_r[1] <= cfg_wdata;
        CFG_MIN_Z:     box_lo_r[2] <= cfg_wdata;
        CFG_MAX_X:     box_hi_r[0] <= cfg_wdata;
        CFG_MAX_Y:     box_hi_r[1] <= cfg_wdata;
        CFG_MAX_Z:     box_hi_r[2] <= cfg_wdata;
        CFG_VALID_TRI: vt_r        <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign lc = load_count(vt_r);

  sah_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .ev_ax    (in_tdata[1:0]),
    .ev_pos   (in_tdata[33:2]),
    .ev_kind  (in_tuser),
    .ev_last  (in_tlast),
    .lc       (lc),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  sah_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  sah_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_rd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .box_lo        (box_lo_r),
    .box_hi        (box_hi_r),
    .lc            (lc),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .best_axis     (best_axis),
    .best_position (best_position),
    .best_cost     (best_cost),
    .planar_side   (planar_side),
    .make_leaf     (make_leaf)
  );

  assign out_tdata = {4'b0, make_leaf, planar_side, best_cost, best_position, best_axis};

  `SAH_NEVER(a_push_full, q_push && q_full)
  `SAH_NEVER(a_pop_empty, q_pop && q_empty)

endmodule

// ===== tb/sah_split_plane_sweep_checker.sv =====
`timescale 1ns / 1ps
module sah_split_plane_sweep_checker import sah_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [39:0]          in_tdata,
  input  logic [KIND_W-1:0]    in_tuser,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [71:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output int                   fail_count,
  output int                   planes_pending
);

  typedef struct packed {
    logic [1:0]  ax;
    logic [31:0] pos;
    logic [31:0] cost;
    logic        side;
    logic        leaf;
  } plane_t;

  plane_t best_q[$];

  longint          box_lo[3];
  longint          box_hi[3];
  logic [16:0]     tri_reg;

  logic [1:0]      sweep_ax;
  logic [31:0]     grp_pos;
  logic            grp_open;
  int unsigned     n_end, n_planar, n_start, n_left, n_right;
  logic [1:0]      best_ax;
  logic [31:0]     best_pos, best_cost;
  logic            best_side;

  function automatic int unsigned tri_count();
    return (tri_reg > 17'd65536) ? 65536 : int'(tri_reg);
  endfunction

  function automatic int unsigned cnt_add(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > 65536) ? 65536 : int'(s);
  endfunction

  function automatic longint unsigned plane_cost(longint unsigned pl, longint unsigned pr,
                                                 longint unsigned nl, longint unsigned nr,
                                                 longint unsigned rl, longint unsigned rr);
    longint unsigned w, c;
    w = pl * nl + pr * nr;
    c = 65536 + ((w * 91750) >> 16);
    if (nl == 0)
      c = (c * (52429 + ((13107 * rr) >> 16))) >> 16;
    else if (nr == 0)
      c = (c * (52429 + ((13107 * rl) >> 16))) >> 16;
    return (c > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : c;
  endfunction

  task automatic sah_eval(input logic [1:0] ax, input logic [31:0] pos,
                          input longint unsigned nl, input longint unsigned np,
                          input longint unsigned nr,
                          output logic [31:0] cost, output logic side);
    longint unsigned ext[3];
    longint unsigned ea, b, c, lenl, lenr, sa, sl, sr, area, areal, arear;
    longint unsigned pl, pr, rl, rr, cl, crt;
    longint          d;
    int              sh, a;
    sh = 0;
    a = int'(ax);
    for (int i = 0; i < 3; i++) begin
      d = box_hi[i] - box_lo[i];
      ext[i] = (d < 0) ? 0 : d;
      if (ext[i] >= 64'h8000_0000) sh = 1;
    end
    ea = ext[a];
    b = ext[(a + 1) % 3] >> sh;
    c = ext[(a + 2) % 3] >> sh;
    d = longint'($signed(pos)) - box_lo[a];
    lenl = (d < 0) ? 0 : d;
    if (lenl > ea) lenl = ea;
    lenr = ea - lenl;
    sa = ea >> sh;
    sl = lenl >> sh;
    sr = sa - sl;
    area = sa * (b + c) + b * c;
    if (area == 0 || ea == 0) begin
      cost = 32'hFFFF_FFFF;
      side = 1'b0;
      return;
    end
    areal = sl * (b + c) + b * c;
    arear = sr * (b + c) + b * c;
    while (area >= (64'd1 << 47)) begin
      area = area >> 1;
      areal = areal >> 1;
      arear = arear >> 1;
    end
    pl = (areal << 16) / area;
    pr = (arear << 16) / area;
    rl = (lenl << 16) / ea;
    rr = (lenr << 16) / ea;
    cl = plane_cost(pl, pr, nl + np, nr, rl, rr);
    crt = plane_cost(pl, pr, nl, np + nr, rl, rr);
    if (cl <= crt) begin
      cost = cl[31:0];
      side = 1'b0;
    end else begin
      cost = crt[31:0];
      side = 1'b1;
    end
  endtask

  task automatic close_group();
    int unsigned sub, nr;
    logic [31:0] cost;
    logic        side;
    sub = cnt_add(n_planar, n_end);
    nr = (n_right > sub) ? n_right - sub : 0;
    sah_eval(sweep_ax, grp_pos, n_left, n_planar, nr, cost, side);
    if (cost < best_cost) begin
      best_cost = cost;
      best_side = side;
      best_ax = sweep_ax;
      best_pos = grp_pos;
    end
    n_left = cnt_add(n_left, cnt_add(n_start, n_planar));
    n_right = nr;
  endtask

  task automatic restart_sweep();
    sweep_ax = AX_X;
    grp_pos = '0;
    grp_open = 1'b0;
    n_end = 0;
    n_planar = 0;
    n_start = 0;
    n_left = 0;
    n_right = tri_count();
    best_ax = AX_X;
    best_pos = POS_MAX;
    best_cost = COST_MAX;
    best_side = 1'b0;
  endtask

  task automatic take_event(input logic [1:0] ax, input logic [31:0] pos,
                            input logic [1:0] kind, input logic lst);
    logic   new_axis, new_group;
    plane_t p;
    if (ax != AX_NULL && kind != KIND_NULL) begin
      new_axis = !grp_open || ax != sweep_ax;
      new_group = new_axis || pos != grp_pos;
      if (grp_open && new_group) close_group();
      if (new_axis) begin
        n_left = 0;
        n_right = tri_count();
        sweep_ax = ax;
      end
      if (new_group) begin
        grp_pos = pos;
        n_end = 0;
        n_planar = 0;
        n_start = 0;
        grp_open = 1'b1;
      end
      case (kind)
        KIND_END:    n_end = cnt_add(n_end, 1);
        KIND_PLANAR: n_planar = cnt_add(n_planar, 1);
        default:     n_start = cnt_add(n_start, 1);
      endcase
    end
    if (!lst) return;
    if (grp_open) close_group();
    p.ax = best_ax;
    p.pos = best_pos;
    p.cost = best_cost;
    p.side = best_side;
    p.leaf = (best_cost == COST_MAX) ||
             (longint'(best_cost) >= 64'd91750 * tri_count());
    best_q.insert(best_q.size(), p);
    restart_sweep();
  endtask

  plane_t got, want;

  assign planes_pending = best_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = 0;
        box_hi[i] = 0;
      end
      tri_reg = '0;
      restart_sweep();
      best_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_X:     box_lo[0] = longint'($signed(cfg_wdata));
          CFG_MIN_Y:     box_lo[1] = longint'($signed(cfg_wdata));
          CFG_MIN_Z:     box_lo[2] = longint'($signed(cfg_wdata));
          CFG_MAX_X:     box_hi[0] = longint'($signed(cfg_wdata));
          CFG_MAX_Y:     box_hi[1] = longint'($signed(cfg_wdata));
          CFG_MAX_Z:     box_hi[2] = longint'($signed(cfg_wdata));
          CFG_VALID_TRI: tri_reg = cfg_wdata[16:0];
          default: ;
        endcase
        // hold the right count in step with the register while idle
        if (!grp_open) n_right = tri_count();
      end
      if (in_tvalid && in_tready)
        take_event(in_tdata[1:0], in_tdata[33:2], in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[33:2], out_tdata[65:34], out_tdata[66],
               out_tdata[67]};
        if (best_q.size() == 0) begin
          $display("%0t: unexpected plane request, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = best_q.pop_front();
          if (got !== want) begin
            $display("%0t: plane mismatch: axis %0d/%0d pos %h/%h cost %h/%h side %b/%b leaf %b/%b",
                     $time, want.ax, got.ax, want.pos, got.pos, want.cost, got.cost,
                     want.side, got.side, want.leaf, got.leaf);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sah_split_plane_sweep_core_tb.sv =====
`timescale 1ns / 1ps
module sah_split_plane_sweep_core_tb;
  import sah_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;
  logic [KIND_W-1:0]    in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [71:0]          out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  int                   fail_count;
  int                   planes_pending;

  logic                 calm;
  logic                 hold_go;
  int                   sent;
  logic [31:0]          lo_v[3];
  logic [31:0]          hi_v[3];

  sah_split_plane_sweep_core dut (.*);

  sah_split_plane_sweep_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_tready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [1:0] ax, input logic [31:0] pos,
                            input logic [1:0] kind, input logic lst);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, pos, ax};
    in_tuser <= kind;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (planes_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_box(input logic [31:0] tri_n);
    logic [CFG_IDX_W-1:0] idx[7];
    logic [31:0]          val[7];
    idx = '{CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z, CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z, CFG_VALID_TRI};
    val = '{lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2], tri_n};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one sweep: runs of sorted groups per axis, some noise, last on the final event
  task automatic sweep(input int groups);
    logic [1:0]  ax, kind;
    logic [31:0] pos;
    int          per, k;
    ax = 2'($urandom_range(2));
    pos = lo_v[ax] - 32'($urandom_range(4096));
    for (int g = 0; g < groups; g++) begin
      if ($urandom_range(99) < 12) begin
        ax = 2'($urandom_range(2));
        pos = lo_v[ax] - 32'($urandom_range(4096));
      end
      pos = pos + 32'($urandom_range(1, 1 << ($urandom_range(24))));
      per = $urandom_range(1, 3);
      k = 0;
      for (int e = 0; e < per; e++) begin
        k = $urandom_range(k, 2);
        kind = ($urandom_range(99) < 8) ? 2'($urandom_range(2)) : 2'(k);
        if ($urandom_range(99) < 6)
          send_event(2'($urandom_range(3)), $urandom, 2'($urandom_range(3)), 1'b0);
        send_event(ax, pos, kind, (g == groups - 1) && (e == per - 1));
      end
    end
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_END;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_X;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero box straight after reset: nothing can be kept
    send_event(AX_X, 32'h0001_0000, KIND_START, 1'b0);
    send_event(AX_X, 32'h0002_0000, KIND_END, 1'b1);
    wait_idle();

    for (int i = 0; i < 3; i++) begin
      lo_v[i] = 32'h0000_0000;
      hi_v[i] = 32'h000A_0000;
    end
    write_box(32'd4);
    send_event(AX_X, 32'h8000_0000, KIND_START, 1'b0);
    send_event(AX_X, 32'h0001_0000, KIND_END, 1'b0);
    send_event(AX_X, 32'h0001_0000, KIND_START, 1'b0);
    send_event(AX_X, 32'h0001_0000, KIND_PLANAR, 1'b0);
    send_event(AX_NULL, 32'h5555_5555, KIND_START, 1'b0);
    send_event(AX_Y, 32'hAAAA_AAAA, KIND_NULL, 1'b0);
    send_event(AX_X, 32'h0004_0000, KIND_PLANAR, 1'b0);
    send_event(AX_X, 32'h7FFF_FFFF, KIND_END, 1'b0);
    send_event(AX_Y, 32'h0003_0000, KIND_START, 1'b0);
    send_event(AX_Z, 32'h0005_0000, KIND_END, 1'b0);
    send_event(AX_X, 32'h0002_0000, KIND_START, 1'b0);
    send_event(AX_NULL, 32'hFFFF_FFFF, KIND_NULL, 1'b1);
    send_event(AX_NULL, 32'h0, KIND_END, 1'b1);
    wait_idle();

    phase = 0;
    while (sent < 900) begin
      case (phase % 6)
        0: begin
          for (int i = 0; i < 3; i++) begin
            lo_v[i] = 32'h8000_0000;
            hi_v[i] = 32'h7FFF_FFFF;
          end
          write_box(32'd131071);
        end
        1: begin
          for (int i = 0; i < 3; i++) begin
            lo_v[i] = $urandom;
            hi_v[i] = lo_v[i] - 32'($urandom_range(65536));
          end
          write_box(32'd65536);
        end
        2: begin
          lo_v[0] = 32'h0;
          hi_v[0] = 32'h0;
          lo_v[1] = 32'h0;
          hi_v[1] = 32'h0001_0000;
          lo_v[2] = 32'h0;
          hi_v[2] = 32'h0;
          write_box(32'd0);
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            lo_v[i] = 32'($signed(24'($urandom)));
            hi_v[i] = lo_v[i] + 32'($urandom_range(1, 1 << 25));
          end
          write_box(32'($urandom_range(0, 40)));
        end
      endcase
      calm = (phase == 4);
      if (phase == 3) begin
        @(negedge clk);
        hold_go <= 1'b1;
        @(negedge clk);
        hold_go <= 1'b0;
        sweep(40);
      end
      for (int s = 0; s < 6; s++) sweep($urandom_range(2, 18));
      wait_idle();
      phase++;
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (planes_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
